/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker modules of the tile span tracker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define DTST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtst: same-cycle check failed");

// next-cycle implication, off during reset
`define DTST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtst: next-cycle check failed");

// next-cycle implication, also checked across reset
`define DTST_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dtst: reset check failed");

`endif

/* rtl/core/dtst_pkg.sv */
// Package of the dirty tile span tracker: frame geometry, widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps

package dtst_pkg;

   localparam int TILE_ROWS     = 8;
   localparam int TILES_PER_ROW = 16;
   localparam int TILE_BYTES    = 8;

   localparam int ROW_BYTES   = TILES_PER_ROW * TILE_BYTES;
   localparam int FRAME_BYTES = TILE_ROWS * ROW_BYTES;

   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int ROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int TILE_W = $clog2(TILES_PER_ROW);
   localparam int TB_W   = (TILE_BYTES > 1) ? $clog2(TILE_BYTES) : 1;
   localparam int SPAN_W = TILE_W + 1;
   localparam int SUM_W  = $clog2(TILE_ROWS * TILES_PER_ROW + 1);

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int ROW_FIELD_W = 3;
   localparam int FIRST_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int THRESH_W    = 8;
   localparam int CMP_W       = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd80;
   localparam logic [SPAN_W-1:0]   NO_TILE      = SPAN_W'(TILES_PER_ROW);

   typedef enum logic [KIND_W-1:0] {
      KIND_SPAN = 2'd0,
      KIND_FULL = 2'd1,
      KIND_NONE = 2'd2
   } update_kind_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SUM,
      EMIT_OUT
   } emit_state_type;

   typedef struct packed {
      logic [SPAN_W-1:0] first;
      logic [TILE_W-1:0] last;
   } row_span_type;

   function automatic logic [SPAN_W-1:0] span_of(row_span_type s);
      return {1'b0, s.last} - s.first + SPAN_W'(1);
   endfunction

endpackage

/* rtl/core/dtst_req_if.sv */
// Request channel of the tile span tracker: one frame byte per transfer.
// Depends on dtst_pkg.
`timescale 1ns / 1ps

interface dtst_req_if;
   import dtst_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;

   modport source (output valid, output frame_byte, input ready);
   modport sink   (input valid, input frame_byte, output ready);
endinterface

/* rtl/core/dtst_rsp_if.sv */
// Response channel of the tile span tracker: one update result per transfer.
// Depends on dtst_pkg.
`timescale 1ns / 1ps

interface dtst_rsp_if;
   import dtst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      update_kind;
   logic [ROW_FIELD_W-1:0] tile_row;
   logic [FIRST_W-1:0]     first_tile;
   logic [COUNT_W-1:0]     tile_count;
   logic                   final_result;

   modport source (output valid, output update_kind, output tile_row, output first_tile,
                   output tile_count, output final_result, input ready);
   modport sink   (input valid, input update_kind, input tile_row, input first_tile,
                   input tile_count, input final_result, output ready);
endinterface

/* rtl/core/dirty_tile_span_tracker_top.sv */
// Top level of the dirty tile span tracker: input scan stage and result stage.
// Depends on dtst_pkg, dtst_req_if, dtst_rsp_if, dtst_scan and dtst_emit.
`timescale 1ns / 1ps

// Takes one frame byte per cycle, unless stalled, in row-major tile order and
// compares it, via the input register, with the stored front frame, which then
// holds the new byte. After a frame's last byte its row spans are captured and
// results registered out, one per cycle while the response side is ready, with
// final_result on the last: a full-update result when the changed tile total
// exceeds the threshold, else one span per changed row or one no-update result.
// Input stalls only when a frame's last byte arrives while results of the
// previous frame are still waiting on the response side. The front memory
// needs no clearing pass: the first frame after reset compares against zero.
module dirty_tile_span_tracker_top (
   input  logic                          clock,
   input  logic                          reset,
   dtst_req_if.sink                      req_ch,
   dtst_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [dtst_pkg::THRESH_W-1:0] csr_wr_data
);
   import dtst_pkg::*;

   logic                         emit_busy;
   logic                         frame_done;
   row_span_type [TILE_ROWS-1:0] rows_upd;

   dtst_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .emit_busy  (emit_busy),
      .frame_done (frame_done),
      .rows_upd   (rows_upd)
   );

   dtst_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .frame_done  (frame_done),
      .rows_upd    (rows_upd),
      .busy        (emit_busy),
      .rsp         (rsp_ch)
   );

endmodule

/* rtl/core/dtst_scan.sv */
// Input stage of the tile span tracker: front frame memory, byte compare and
// per-row first/last changed tile tracking. Depends on dtst_pkg and dtst_req_if.
`timescale 1ns / 1ps

module dtst_scan (
   input  logic                                          clock,
   input  logic                                          reset,
   dtst_req_if.sink                                      req,
   input  logic                                          emit_busy,
   output logic                                          frame_done,
   output dtst_pkg::row_span_type [dtst_pkg::TILE_ROWS-1:0] rows_upd
);
   import dtst_pkg::*;

   logic [BYTE_W-1:0] mem [FRAME_BYTES];

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TB_W-1:0]   bcnt_ff, bcnt_in;
   logic [TILE_W-1:0] tcnt_ff, tcnt_in;
   logic [ROW_W-1:0]  rcnt_ff, rcnt_in;

   logic              a_valid_ff, a_valid_in;
   logic [BYTE_W-1:0] a_byte_ff;
   logic [BYTE_W-1:0] a_old_ff;
   logic [ADDR_W-1:0] a_addr_ff;
   logic [TILE_W-1:0] a_tile_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic              a_tile_end_ff;
   logic              a_frame_end_ff;

   logic filled_ff, filled_in;
   logic tile_diff_ff, tile_diff_in;
   row_span_type [TILE_ROWS-1:0] rows_ff, rows_in, rows_clear;

   logic accept, advance;
   logic tile_end_now, row_end_now, last_row_now, frame_end_now;
   logic diff, td;

   assign advance   = a_valid_ff && !(a_frame_end_ff && emit_busy);
   assign req.ready = !a_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign tile_end_now  = bcnt_ff == TB_W'(TILE_BYTES - 1);
   assign row_end_now   = tcnt_ff == TILE_W'(TILES_PER_ROW - 1);
   assign last_row_now  = rcnt_ff == ROW_W'(TILE_ROWS - 1);
   assign frame_end_now = tile_end_now && row_end_now && last_row_now;

   assign frame_done = advance && a_frame_end_ff;

   always_comb begin
      addr_in = addr_ff;
      bcnt_in = bcnt_ff;
      tcnt_in = tcnt_ff;
      rcnt_in = rcnt_ff;
      if (accept) begin
         addr_in = frame_end_now ? '0 : addr_ff + ADDR_W'(1);
         bcnt_in = tile_end_now ? '0 : bcnt_ff + TB_W'(1);
         if (tile_end_now) begin
            tcnt_in = row_end_now ? '0 : tcnt_ff + TILE_W'(1);
            if (row_end_now) begin
               rcnt_in = last_row_now ? '0 : rcnt_ff + ROW_W'(1);
            end
         end
      end
   end

   // until the first frame has been written, the front frame reads as zero
   assign diff = filled_ff ? (a_old_ff != a_byte_ff) : (a_byte_ff != '0);
   assign td   = tile_diff_ff | diff;

   always_comb begin
      rows_upd = rows_ff;
      if (a_tile_end_ff && td) begin
         if (rows_ff[a_row_ff].first == NO_TILE) begin
            rows_upd[a_row_ff].first = {1'b0, a_tile_ff};
         end
         rows_upd[a_row_ff].last = a_tile_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < TILE_ROWS; r++) begin
         rows_clear[r].first = NO_TILE;
         rows_clear[r].last  = '0;
      end
   end

   always_comb begin
      a_valid_in   = accept || (a_valid_ff && !advance);
      filled_in    = filled_ff;
      tile_diff_in = tile_diff_ff;
      rows_in      = rows_ff;
      if (advance) begin
         tile_diff_in = a_tile_end_ff ? 1'b0 : td;
         rows_in      = a_frame_end_ff ? rows_clear : rows_upd;
         if (a_frame_end_ff) begin
            filled_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         bcnt_ff      <= '0;
         tcnt_ff      <= '0;
         rcnt_ff      <= '0;
         a_valid_ff   <= 1'b0;
         filled_ff    <= 1'b0;
         tile_diff_ff <= 1'b0;
         rows_ff      <= rows_clear;
      end else begin
         addr_ff      <= addr_in;
         bcnt_ff      <= bcnt_in;
         tcnt_ff      <= tcnt_in;
         rcnt_ff      <= rcnt_in;
         a_valid_ff   <= a_valid_in;
         filled_ff    <= filled_in;
         tile_diff_ff <= tile_diff_in;
         rows_ff      <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_byte_ff      <= req.frame_byte;
         a_addr_ff      <= addr_ff;
         a_tile_ff      <= tcnt_ff;
         a_row_ff       <= rcnt_ff;
         a_tile_end_ff  <= tile_end_now;
         a_frame_end_ff <= frame_end_now;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_old_ff <= mem[addr_ff];
      end
      if (advance) begin
         mem[a_addr_ff] <= a_byte_ff;
      end
   end

endmodule

/* rtl/core/dtst_emit.sv */
// Output stage of the tile span tracker: frame snapshot, span total against the
// threshold register, and the result walk. Depends on dtst_pkg and dtst_rsp_if.
`timescale 1ns / 1ps

module dtst_emit (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_wr_en,
   input  logic [dtst_pkg::THRESH_W-1:0]                 csr_wr_data,
   input  logic                                          frame_done,
   input  dtst_pkg::row_span_type [dtst_pkg::TILE_ROWS-1:0] rows_upd,
   output logic                                          busy,
   dtst_rsp_if.source                                    rsp
);
   import dtst_pkg::*;

   emit_state_type state_ff, state_in;

   logic [THRESH_W-1:0]          thresh_ff;
   row_span_type [TILE_ROWS-1:0] snap_ff;
   logic [TILE_ROWS-1:0]         mask_ff;
   logic                         full_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]      kind_ff;
   logic [ROW_FIELD_W-1:0] row_ff;
   logic [FIRST_W-1:0]     first_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   final_ff;

   logic [SUM_W-1:0]     total;
   logic [TILE_ROWS-1:0] present;
   logic                 over;
   logic [ROW_W-1:0]     pick_idx;
   logic [TILE_ROWS-1:0] pick_oh;
   logic                 last_pick;
   logic                 load, snap_en, sum_en, emit_en;

   always_comb begin
      total   = '0;
      present = '0;
      for (int r = 0; r < TILE_ROWS; r++) begin
         if (snap_ff[r].first != NO_TILE) begin
            present[r] = 1'b1;
            total      = total + SUM_W'(span_of(snap_ff[r]));
         end
      end
   end

   assign over = CMP_W'(total) > CMP_W'(thresh_ff);

   always_comb begin
      pick_idx = '0;
      pick_oh  = '0;
      for (int r = TILE_ROWS - 1; r >= 0; r--) begin
         if (mask_ff[r]) begin
            pick_idx    = ROW_W'(r);
            pick_oh     = '0;
            pick_oh[r]  = 1'b1;
         end
      end
   end

   assign last_pick = full_ff || ((mask_ff & ~pick_oh) == '0);
   assign load      = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EMIT_IDLE: begin
            if (frame_done) state_in = EMIT_SUM;
         end
         EMIT_SUM: begin
            state_in = EMIT_OUT;
         end
         EMIT_OUT: begin
            if (load && last_pick) state_in = EMIT_IDLE;
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   always_comb begin
      busy    = 1'b1;
      snap_en = 1'b0;
      sum_en  = 1'b0;
      emit_en = 1'b0;
      unique case (state_ff)
         EMIT_IDLE: begin
            busy    = 1'b0;
            snap_en = frame_done;
         end
         EMIT_SUM: begin
            sum_en = 1'b1;
         end
         EMIT_OUT: begin
            emit_en = load;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit_en || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMIT_IDLE;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_en) begin
         snap_ff <= rows_upd;
      end
      if (sum_en) begin
         full_ff <= over;
         mask_ff <= present;
      end else if (emit_en) begin
         mask_ff <= mask_ff & ~pick_oh;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         priority if (full_ff) begin
            kind_ff  <= KIND_FULL;
            row_ff   <= '0;
            first_ff <= '0;
            count_ff <= '0;
            final_ff <= 1'b1;
         end else if (mask_ff == '0) begin
            kind_ff  <= KIND_NONE;
            row_ff   <= '0;
            first_ff <= '0;
            count_ff <= '0;
            final_ff <= 1'b1;
         end else begin
            kind_ff  <= KIND_SPAN;
            row_ff   <= ROW_FIELD_W'(pick_idx);
            first_ff <= FIRST_W'(snap_ff[pick_idx].first);
            count_ff <= COUNT_W'(span_of(snap_ff[pick_idx]));
            final_ff <= last_pick;
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.update_kind  = kind_ff;
   assign rsp.tile_row     = row_ff;
   assign rsp.first_tile   = first_ff;
   assign rsp.tile_count   = count_ff;
   assign rsp.final_result = final_ff;

endmodule

/* rtl/core/dtst_checker.sv */
// Port-level checks of the tile span tracker, bound to the top level.
// Depends on dtst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [dtst_pkg::KIND_W-1:0]      update_kind,
   input logic [dtst_pkg::ROW_FIELD_W-1:0] tile_row,
   input logic [dtst_pkg::FIRST_W-1:0]     first_tile,
   input logic [dtst_pkg::COUNT_W-1:0]     tile_count,
   input logic                             final_result
);
   import dtst_pkg::*;

   `DTST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(update_kind) && $stable(tile_row) && $stable(first_tile) && $stable(tile_count) && $stable(final_result))
   `DTST_ASSERT_IMP(a_whole_frame, clock, reset, rsp_valid && update_kind != KIND_SPAN, final_result && tile_row == '0 && first_tile == '0 && tile_count == '0)
   `DTST_ASSERT_IMP(a_span_fits, clock, reset, rsp_valid && update_kind == KIND_SPAN, tile_count != '0 && (COUNT_W'(first_tile) + tile_count) <= COUNT_W'(TILES_PER_ROW))
   `DTST_ASSERT_NEXT_NR(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind dirty_tile_span_tracker_top dtst_checker u_dtst_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .update_kind  (rsp_ch.update_kind),
   .tile_row     (rsp_ch.tile_row),
   .first_tile   (rsp_ch.first_tile),
   .tile_count   (rsp_ch.tile_count),
   .final_result (rsp_ch.final_result)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench of dirty_tile_span_tracker_top: streams whole frames one byte per transfer,
// predicts every update result and checks it field by field on the response channel.
// Depends on dtst_pkg, dtst_req_if, dtst_rsp_if and the RTL of the tracker.

module testbench;
   import dtst_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int RESULT_GOAL = 80;

   typedef struct {
      update_kind_type        kind;
      logic [ROW_FIELD_W-1:0] row;
      logic [FIRST_W-1:0]     first;
      logic [COUNT_W-1:0]     count;
      logic                   last;
   } tile_update_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;

   dtst_req_if req_bus ();
   dtst_rsp_if rsp_bus ();

   dirty_tile_span_tracker_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [BYTE_W-1:0]   front_copy [FRAME_BYTES];
   int                  scan_pos;
   logic                tile_changed;
   int                  row_first [TILE_ROWS];
   int                  row_last  [TILE_ROWS];
   logic [THRESH_W-1:0] threshold;
   tile_update_type     due_updates [$];
   int                  updates_predicted;

   // stimulus and checking state
   logic [BYTE_W-1:0]   next_frame [FRAME_BYTES];
   logic [BYTE_W-1:0]   byte_backlog [$];
   int                  idle_pct;
   logic                req_taken;
   int                  error_count;
   int                  quiet_cycles;
   tile_update_type     want;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_tracking();
      for (int r = 0; r < TILE_ROWS; r++) begin
         row_first[r] = TILES_PER_ROW;
         row_last[r]  = 0;
      end
      tile_changed = 1'b0;
   endfunction

   function automatic void track_frame_byte(logic [BYTE_W-1:0] value);
      int              row;
      int              tile;
      int              total;
      int              final_row;
      int              queued_n;
      tile_update_type upd;
      if (front_copy[scan_pos] != value) tile_changed = 1'b1;
      front_copy[scan_pos] = value;
      if (scan_pos % TILE_BYTES == TILE_BYTES - 1) begin
         row  = scan_pos / ROW_BYTES;
         tile = (scan_pos % ROW_BYTES) / TILE_BYTES;
         if (tile_changed) begin
            if (row_first[row] == TILES_PER_ROW) row_first[row] = tile;
            row_last[row] = tile;
         end
         tile_changed = 1'b0;
      end
      if (scan_pos == FRAME_BYTES - 1) begin
         total     = 0;
         final_row = -1;
         queued_n  = due_updates.size();
         for (int r = 0; r < TILE_ROWS; r++) begin
            if (row_first[r] != TILES_PER_ROW) begin
               total += row_last[r] - row_first[r] + 1;
               final_row = r;
            end
         end
         upd = '{KIND_NONE, '0, '0, '0, 1'b1};
         if (total > int'(threshold)) begin
            upd.kind = KIND_FULL;
            due_updates.push_back(upd);
         end else if (final_row < 0) begin
            due_updates.push_back(upd);
         end else begin
            for (int r = 0; r < TILE_ROWS; r++) begin
               if (row_first[r] != TILES_PER_ROW) begin
                  upd.kind  = KIND_SPAN;
                  upd.row   = ROW_FIELD_W'(r);
                  upd.first = FIRST_W'(row_first[r]);
                  upd.count = COUNT_W'(row_last[r] - row_first[r] + 1);
                  upd.last  = (r == final_row);
                  due_updates.push_back(upd);
               end
            end
         end
         updates_predicted += due_updates.size() - queued_n;
         clear_tracking();
         scan_pos = 0;
      end else begin
         scan_pos++;
      end
   endfunction

   // sample both channels, predict, check
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            track_frame_byte(req_bus.frame_byte);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_updates.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: kind %0d row %0d first %0d count %0d final %0b",
                           rsp_bus.update_kind, rsp_bus.tile_row, rsp_bus.first_tile,
                           rsp_bus.tile_count, rsp_bus.final_result);
            end else begin
               want = due_updates.pop_front();
               if (rsp_bus.update_kind !== want.kind || rsp_bus.tile_row !== want.row ||
                   rsp_bus.first_tile !== want.first || rsp_bus.tile_count !== want.count ||
                   rsp_bus.final_result !== want.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("result differs: expected kind %0d row %0d first %0d count %0d ",
                            want.kind, want.row, want.first, want.count);
                     $display("final %0b, got kind %0d row %0d first %0d count %0d final %0b",
                              want.last, rsp_bus.update_kind, rsp_bus.tile_row,
                              rsp_bus.first_tile, rsp_bus.tile_count, rsp_bus.final_result);
                  end
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("dirty_tile_span_tracker_top: mismatch");
            $finish;
         end
      end
   end

   // drive requests from the backlog, throttle the response side
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_bus.valid      <= 1'b1;
               req_bus.frame_byte <= byte_backlog.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic queue_frame();
      for (int i = 0; i < FRAME_BYTES; i++) byte_backlog.push_back(next_frame[i]);
   endtask

   task automatic fill_frame(input int lo, input int hi, input logic [BYTE_W-1:0] value);
      for (int i = lo; i < hi; i++) next_frame[i] = value;
   endtask

   // flip one or more bits of one byte somewhere in the tile
   task automatic touch_tile(input int row, input int tile);
      int idx;
      idx = row * ROW_BYTES + tile * TILE_BYTES + $urandom_range(TILE_BYTES - 1);
      next_frame[idx] ^= BYTE_W'($urandom_range(255, 1));
   endtask

   // hold until every byte is in and every result is out, then let the pipe drain
   task automatic settle();
      while (byte_backlog.size() != 0 || req_bus.valid || due_updates.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      threshold   = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_frame();
      int style;
      int row_pct;
      int f;
      int l;
      style = $urandom_range(9);
      if (style == 0) begin
         for (int i = 0; i < FRAME_BYTES; i++) next_frame[i] = BYTE_W'($urandom);
      end else begin
         row_pct = (style < 4) ? 15 : (style < 8) ? 50 : 100;
         for (int r = 0; r < TILE_ROWS; r++) begin
            if ($urandom_range(99) < row_pct) begin
               f = $urandom_range(TILES_PER_ROW - 1);
               l = $urandom_range(TILES_PER_ROW - 1, f);
               touch_tile(r, f);
               touch_tile(r, l);
               for (int t = f + 1; t < l; t++)
                  if ($urandom_range(1)) touch_tile(r, t);
            end
         end
      end
   endtask

   initial begin
      int frames;
      int pick;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = THRESH_RESET;
      req_bus.valid      = 1'b0;
      req_bus.frame_byte = '0;
      rsp_bus.ready      = 1'b0;
      idle_pct           = 34;
      req_taken          = 1'b0;
      error_count        = 0;
      quiet_cycles       = 0;
      updates_predicted  = 0;
      scan_pos           = 0;
      threshold          = THRESH_RESET;
      clear_tracking();
      for (int i = 0; i < FRAME_BYTES; i++) begin
         front_copy[i] = '0;
         next_frame[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first frame matches the cleared store, then every tile changes
      queue_frame();
      fill_frame(0, FRAME_BYTES, 8'hFF);
      queue_frame();

      // threshold equal to the largest possible total: spans on every row, then nothing
      write_threshold(8'd128);
      fill_frame(0, FRAME_BYTES, 8'h00);
      queue_frame();
      queue_frame();

      // a single changed tile above a zero threshold
      write_threshold(8'd0);
      next_frame[FRAME_BYTES - 1] = 8'h80;
      queue_frame();

      // threshold out of reach: sparse spans, some on edge tiles, then every row
      write_threshold(8'd255);
      next_frame[0]                                           = 8'h01;
      next_frame[FRAME_BYTES - 1]                             = 8'h00;
      next_frame[3 * ROW_BYTES + 7 * TILE_BYTES + 3]          = 8'h7F;
      next_frame[2 * ROW_BYTES + 3 * TILE_BYTES]              = 8'h10;
      next_frame[2 * ROW_BYTES + 13 * TILE_BYTES - 1]         = 8'h02;
      queue_frame();
      fill_frame(0, FRAME_BYTES, 8'h5A);
      queue_frame();

      // total exactly at the reset threshold, then one tile over it
      write_threshold(THRESH_RESET);
      fill_frame(0, 5 * ROW_BYTES, 8'hA5);
      queue_frame();
      for (int i = 0; i < 5 * ROW_BYTES; i++) next_frame[i] ^= 8'hFF;
      touch_tile(5, 3);
      queue_frame();

      frames = 0;
      while (updates_predicted < RESULT_GOAL) begin
         if (frames % 5 == 0) begin
            pick = $urandom_range(4);
            write_threshold(pick == 0 ? 8'd0 : pick == 1 ? 8'd128 : pick == 2 ? 8'd255 :
                            THRESH_W'($urandom_range(128)));
         end
         idle_pct = (frames >= 3 && frames < 6) ? 0 : 34;
         random_frame();
         queue_frame();
         while (byte_backlog.size() > 64) @(posedge clock);
         frames++;
      end

      idle_pct = 34;
      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && due_updates.size() == 0)
         $display("dirty_tile_span_tracker_top: match");
      else
         $display("dirty_tile_span_tracker_top: mismatch");
      $finish;
   end

endmodule
